@@ rtl/ifs_pkg.sv @@
`timescale 1ns / 1ps
// ifs_pkg: shared types, constants and helper functions for the fern point plotter.
// Used by ifs_ctrl, ifs_datapath, ifs_fern_point_plotter and ifs_checker.
package ifs_pkg;

  // default build sizes
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_FRAC_BITS  = 16;

  // field widths
  localparam int POINT_W  = 24;
  localparam int DIM_W    = 9;
  localparam int PIX_W    = 8;
  localparam int CHOICE_W = 7;
  localparam int CFG_IDX_W = 2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [DIM_W-1:0]     DIM_RESET        = 9'd256;

  // action codes
  localparam logic ACT_ITERATE = 1'b0;
  localparam logic ACT_READ    = 1'b1;

  // map split thresholds (first draw of each band)
  localparam logic [CHOICE_W-1:0] CHOICE_B_FIRST = 7'd85;
  localparam logic [CHOICE_W-1:0] CHOICE_C_FIRST = 7'd92;
  localparam logic [CHOICE_W-1:0] CHOICE_D_FIRST = 7'd99;

  // point saturation limits
  localparam logic signed [POINT_W-1:0] PT_MAX = 24'sh7FFFFF;
  localparam logic signed [POINT_W-1:0] PT_MIN = 24'sh800000;

  // pixel scale: col = 2*W*(x+2.5)/10, row index = H*(y+1)/10
  localparam int DEN_STEPS = 10;
  // reciprocal of 10 in 0.16, exact for values below 16384
  localparam logic [12:0] RECIP10     = 13'd6554;
  localparam int          RECIP_SHIFT = 16;

  // intensity update
  localparam logic [PIX_W-1:0] PIX_MAX  = 8'd255;
  localparam logic [PIX_W-1:0] PIX_STEP = 8'd20;

  typedef enum logic [1:0] {
    MAP_STEM  = 2'd0,
    MAP_LEFT  = 2'd1,
    MAP_RIGHT = 2'd2,
    MAP_BASE  = 2'd3
  } map_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic do_mul;
    logic do_sum;
    logic do_scale;
    logic do_div;
    logic do_addr;
    logic do_read;
    logic commit;
    logic clear_wr;
  } ifs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;
    logic clr_last;
    logic out_free;
  } ifs_status_t;

  // coefficient in hundredths to fixed point, rounded half up on the magnitude
  function automatic longint qpos(input int h, input int frac);
    qpos = ((longint'(h) <<< frac) + 50) / 100;
  endfunction

  // 85/7/7/1 split; draws above 99 fall into the last map
  function automatic map_t map_of(input logic [CHOICE_W-1:0] c);
    if (c < CHOICE_B_FIRST)      map_of = MAP_STEM;
    else if (c < CHOICE_C_FIRST) map_of = MAP_LEFT;
    else if (c < CHOICE_D_FIRST) map_of = MAP_RIGHT;
    else                         map_of = MAP_BASE;
  endfunction

endpackage

@@ rtl/ifs_ctrl.sv @@
`timescale 1ns / 1ps
// ifs_ctrl: sequencing state machine for the fern point plotter.
// Depends on ifs_pkg for the command and status structs.
module ifs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ifs_pkg::ifs_status_t status,
  output ifs_pkg::ifs_cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_MUL   = 9'b000000100,
    S_SUM   = 9'b000001000,
    S_SCALE = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_ADDR  = 9'b001000000,
    S_RD    = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.do_mul = !status.is_read;
        state_next = status.is_read ? S_ADDR : S_SUM;
      end
      S_SUM: begin
        cmd.do_sum = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.do_scale = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.do_div = 1'b1;
        state_next = S_ADDR;
      end
      S_ADDR: begin
        cmd.do_addr = 1'b1;
        state_next  = S_RD;
      end
      S_RD: begin
        cmd.do_read = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        // hold until the output register can take the result
        cmd.commit = status.out_free;
        if (status.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

endmodule

@@ rtl/ifs_datapath.sv @@
`timescale 1ns / 1ps
// ifs_datapath: point registers, affine map arithmetic, pixel scaling, framebuffer
// and output register. Depends on ifs_pkg; driven by ifs_ctrl commands.
module ifs_datapath #(
  parameter int MAX_WIDTH  = ifs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ifs_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = ifs_pkg::DEF_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ifs_pkg::ifs_cmd_t               cmd,
  output ifs_pkg::ifs_status_t            status,
  input  logic                            action,
  input  logic [ifs_pkg::CHOICE_W-1:0]    choice,
  input  logic [ifs_pkg::PIX_W-1:0]       read_col,
  input  logic [ifs_pkg::PIX_W-1:0]       read_row,
  input  logic                            wr_en,
  input  logic [ifs_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [ifs_pkg::DIM_W-1:0]       wr_data,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic                            plotted,
  output logic [ifs_pkg::PIX_W-1:0]       pixel_col,
  output logic [ifs_pkg::PIX_W-1:0]       pixel_row,
  output logic [ifs_pkg::PIX_W-1:0]       intensity
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AD    = $clog2(DEPTH);
  localparam int PTW   = ifs_pkg::POINT_W;
  localparam int DW    = ifs_pkg::DIM_W;
  localparam int PXW   = ifs_pkg::PIX_W;
  localparam int CW    = FRAC_BITS + 3;
  localparam int PW    = PTW + CW;
  localparam int AW    = PW + 2;
  localparam int SHW   = AW - FRAC_BITS;
  localparam int SW    = ((FRAC_BITS + 3 > PTW) ? FRAC_BITS + 3 : PTW) + 2;
  localparam int NW    = SW + DW + 1;
  localparam int TW    = NW - FRAC_BITS;

  // map coefficients
  localparam logic signed [CW-1:0] A_AX = CW'(ifs_pkg::qpos(85, FRAC_BITS));
  localparam logic signed [CW-1:0] A_BX = CW'(ifs_pkg::qpos(4, FRAC_BITS));
  localparam logic signed [CW-1:0] A_AY = CW'(-ifs_pkg::qpos(4, FRAC_BITS));
  localparam logic signed [CW-1:0] A_BY = CW'(ifs_pkg::qpos(85, FRAC_BITS));
  localparam logic signed [CW-1:0] A_EY = CW'(ifs_pkg::qpos(160, FRAC_BITS));
  localparam logic signed [CW-1:0] B_AX = CW'(-ifs_pkg::qpos(15, FRAC_BITS));
  localparam logic signed [CW-1:0] B_BX = CW'(ifs_pkg::qpos(28, FRAC_BITS));
  localparam logic signed [CW-1:0] B_AY = CW'(ifs_pkg::qpos(26, FRAC_BITS));
  localparam logic signed [CW-1:0] B_BY = CW'(ifs_pkg::qpos(24, FRAC_BITS));
  localparam logic signed [CW-1:0] B_EY = CW'(ifs_pkg::qpos(44, FRAC_BITS));
  localparam logic signed [CW-1:0] C_AX = CW'(ifs_pkg::qpos(20, FRAC_BITS));
  localparam logic signed [CW-1:0] C_BX = CW'(-ifs_pkg::qpos(26, FRAC_BITS));
  localparam logic signed [CW-1:0] C_AY = CW'(ifs_pkg::qpos(23, FRAC_BITS));
  localparam logic signed [CW-1:0] C_BY = CW'(ifs_pkg::qpos(22, FRAC_BITS));
  localparam logic signed [CW-1:0] C_EY = CW'(ifs_pkg::qpos(160, FRAC_BITS));
  localparam logic signed [CW-1:0] D_BY = CW'(ifs_pkg::qpos(16, FRAC_BITS));

  localparam logic signed [AW-1:0] HALF     = AW'(longint'(1) <<< (FRAC_BITS - 1));
  localparam logic signed [SW-1:0] ONE_FIX  = SW'(longint'(1) <<< FRAC_BITS);
  localparam logic signed [SW-1:0] FIVE_FIX = SW'(longint'(5) <<< FRAC_BITS);
  localparam logic signed [NW-1:0] NEG_DEN  =
    NW'(-(longint'(ifs_pkg::DEN_STEPS) <<< FRAC_BITS));
  localparam logic signed [SHW-1:0] SAT_HI = SHW'(ifs_pkg::PT_MAX);
  localparam logic signed [SHW-1:0] SAT_LO = SHW'(ifs_pkg::PT_MIN);

  // configuration
  logic [DW-1:0] width_reg, height_reg;
  logic [DW-1:0] w_eff, h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= ifs_pkg::DIM_RESET;
      height_reg <= ifs_pkg::DIM_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        ifs_pkg::REG_IMAGE_WIDTH:  width_reg  <= wr_data;
        ifs_pkg::REG_IMAGE_HEIGHT: height_reg <= wr_data;
        default: ;
      endcase
    end
  end

  assign w_eff = (32'(width_reg) > MAX_WIDTH) ? DW'(MAX_WIDTH) : width_reg;
  assign h_eff = (32'(height_reg) > MAX_HEIGHT) ? DW'(MAX_HEIGHT) : height_reg;

  // request capture
  logic               is_read;
  ifs_pkg::map_t      map_sel;
  logic [PXW-1:0]     rcol_q, rrow_q;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      is_read <= (action == ifs_pkg::ACT_READ);
      map_sel <= ifs_pkg::map_of(choice);
      rcol_q  <= read_col;
      rrow_q  <= read_row;
    end
  end

  // coefficient select
  logic signed [CW-1:0] c_ax, c_bx, c_ay, c_by, c_ey;

  always_comb begin
    unique case (map_sel)
      ifs_pkg::MAP_STEM: begin
        c_ax = A_AX; c_bx = A_BX; c_ay = A_AY; c_by = A_BY; c_ey = A_EY;
      end
      ifs_pkg::MAP_LEFT: begin
        c_ax = B_AX; c_bx = B_BX; c_ay = B_AY; c_by = B_BY; c_ey = B_EY;
      end
      ifs_pkg::MAP_RIGHT: begin
        c_ax = C_AX; c_bx = C_BX; c_ay = C_AY; c_by = C_BY; c_ey = C_EY;
      end
      default: begin
        c_ax = '0; c_bx = '0; c_ay = '0; c_by = D_BY; c_ey = '0;
      end
    endcase
  end

  // products of the map
  logic signed [PTW-1:0] point_x, point_y;
  logic signed [PW-1:0]  p_ax, p_bx, p_ay, p_by;
  logic signed [CW-1:0]  ey_q;

  always_ff @(posedge clk) begin
    if (cmd.do_mul) begin
      p_ax <= PW'(c_ax) * PW'(point_x);
      p_bx <= PW'(c_bx) * PW'(point_y);
      p_ay <= PW'(c_ay) * PW'(point_x);
      p_by <= PW'(c_by) * PW'(point_y);
      ey_q <= c_ey;
    end
  end

  // sum, round, floor shift, saturate
  logic signed [AW-1:0]  acc_x, acc_y;
  logic signed [SHW-1:0] sh_x, sh_y;
  logic signed [PTW-1:0] nx_sat, ny_sat;

  assign acc_x = AW'(p_ax) + AW'(p_bx) + HALF;
  assign acc_y = AW'(p_ay) + AW'(p_by) + (AW'(ey_q) <<< FRAC_BITS) + HALF;
  assign sh_x  = SHW'(acc_x >>> FRAC_BITS);
  assign sh_y  = SHW'(acc_y >>> FRAC_BITS);

  always_comb begin
    if (sh_x > SAT_HI)      nx_sat = ifs_pkg::PT_MAX;
    else if (sh_x < SAT_LO) nx_sat = ifs_pkg::PT_MIN;
    else                    nx_sat = PTW'(sh_x);
    if (sh_y > SAT_HI)      ny_sat = ifs_pkg::PT_MAX;
    else if (sh_y < SAT_LO) ny_sat = ifs_pkg::PT_MIN;
    else                    ny_sat = PTW'(sh_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_x <= '0;
      point_y <= '0;
    end else if (cmd.do_sum) begin
      point_x <= nx_sat;
      point_y <= ny_sat;
    end
  end

  // pixel scaling numerators: W*(2x + 5) and H*(y + 1), in 2^-F units
  logic signed [SW-1:0] sx, sy;
  logic signed [NW-1:0] num_c, num_r;

  assign sx = (SW'(point_x) <<< 1) + FIVE_FIX;
  assign sy = SW'(point_y) + ONE_FIX;

  always_ff @(posedge clk) begin
    if (cmd.do_scale) begin
      num_c <= NW'(sx) * NW'($signed({1'b0, w_eff}));
      num_r <= NW'(sy) * NW'($signed({1'b0, h_eff}));
    end
  end

  // divide by 10*2^F, truncating toward zero, with range check
  logic [12:0]          w_x10, h_x10;
  logic signed [TW-1:0] t_c, t_r;
  logic [25:0]          q_prod_c, q_prod_r;
  logic                 in_c, in_r;
  logic [DW-1:0]        col_d, idy_d;
  logic                 in_c_q, in_r_q;
  logic [DW-1:0]        col_q, idy_q;

  assign w_x10 = 13'(w_eff) * 13'(ifs_pkg::DEN_STEPS);
  assign h_x10 = 13'(h_eff) * 13'(ifs_pkg::DEN_STEPS);
  assign t_c   = TW'(num_c >>> FRAC_BITS);
  assign t_r   = TW'(num_r >>> FRAC_BITS);
  assign q_prod_c = 26'(t_c[12:0]) * 26'(ifs_pkg::RECIP10);
  assign q_prod_r = 26'(t_r[12:0]) * 26'(ifs_pkg::RECIP10);

  always_comb begin
    // a small negative numerator truncates to pixel zero
    if (num_c[NW-1]) begin
      in_c  = (w_eff != '0) && (num_c > NEG_DEN);
      col_d = '0;
    end else begin
      in_c  = (t_c < TW'($signed({1'b0, w_x10})));
      col_d = DW'(q_prod_c >> ifs_pkg::RECIP_SHIFT);
    end
    if (num_r[NW-1]) begin
      in_r  = (h_eff != '0) && (num_r > NEG_DEN);
      idy_d = '0;
    end else begin
      in_r  = (t_r < TW'($signed({1'b0, h_x10})));
      idy_d = DW'(q_prod_r >> ifs_pkg::RECIP_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_div) begin
      in_c_q <= in_c;
      in_r_q <= in_r;
      col_q  <= col_d;
      idy_q  <= idy_d;
    end
  end

  // address, hit and result coordinates
  logic [DW-1:0]  row_calc;
  logic [AD-1:0]  iter_addr, read_addr, addr;
  logic           rd_ok, hit;
  logic [PXW-1:0] o_col, o_row;

  assign row_calc  = h_eff - DW'(1) - idy_q;
  assign iter_addr = AD'(row_calc) * AD'(MAX_WIDTH) + AD'(col_q);
  assign read_addr = AD'(rrow_q) * AD'(MAX_WIDTH) + AD'(rcol_q);
  assign rd_ok     = (32'(rcol_q) < MAX_WIDTH) && (32'(rrow_q) < MAX_HEIGHT);

  always_ff @(posedge clk) begin
    if (cmd.do_addr) begin
      if (is_read) begin
        addr  <= read_addr;
        hit   <= rd_ok;
        o_col <= rcol_q;
        o_row <= rrow_q;
      end else begin
        addr  <= iter_addr;
        hit   <= in_c_q && in_r_q;
        o_col <= (in_c_q && in_r_q) ? col_q[PXW-1:0] : '0;
        o_row <= (in_c_q && in_r_q) ? row_calc[PXW-1:0] : '0;
      end
    end
  end

  // framebuffer
  logic [PXW-1:0] frame_mem [DEPTH];
  logic [PXW-1:0] rdata, bumped, mem_wdata, intensity_next;
  logic [AD-1:0]  clr_addr, mem_waddr;
  logic           mem_we, plot_wr;

  assign bumped  = (rdata > (ifs_pkg::PIX_MAX - ifs_pkg::PIX_STEP)) ?
                   ifs_pkg::PIX_MAX : rdata + ifs_pkg::PIX_STEP;
  assign plot_wr   = cmd.commit && !is_read && hit;
  assign mem_we    = cmd.clear_wr || plot_wr;
  assign mem_waddr = cmd.clear_wr ? clr_addr : addr;
  assign mem_wdata = cmd.clear_wr ? '0 : bumped;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_read) begin
      rdata <= frame_mem[addr];
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + AD'(1);
    end
  end

  // output register
  assign intensity_next = hit ? (is_read ? rdata : bumped) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      plotted   <= !is_read && hit;
      pixel_col <= o_col;
      pixel_row <= o_row;
      intensity <= intensity_next;
    end
  end

  // status to controller
  assign status.is_read  = is_read;
  assign status.clr_last = (clr_addr == AD'(DEPTH - 1));
  assign status.out_free = !out_valid || !out_stall;

endmodule

@@ rtl/ifs_fern_point_plotter.sv @@
`timescale 1ns / 1ps
// ifs_fern_point_plotter: top level of the chaos-game fern plotter.
// Depends on ifs_pkg, ifs_ctrl and ifs_datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_stall  | action, choice, read_col, read_row
//  output   | out_valid / out_stall| plotted, pixel_col, pixel_row, intensity
//  config   | wr_en                | wr_index, wr_data
//
// An iterate request runs multiply, sum, scale, divide, address, memory read
// and write back, a read request skips sum, scale and divide; the point
// recurrence and the framebuffer read-modify-write run one request at a time.
// After reset a clearing pass writes zero to all MAX_WIDTH*MAX_HEIGHT pixels
// with in_stall high; config writes are still taken. A stalled result waits
// in the output register; the next request is taken while it waits, and only
// its own write back holds until the register frees.
module ifs_fern_point_plotter #(
  parameter int MAX_WIDTH  = ifs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ifs_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = ifs_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic [ifs_pkg::CHOICE_W-1:0]  choice,
  input  logic [ifs_pkg::PIX_W-1:0]     read_col,
  input  logic [ifs_pkg::PIX_W-1:0]     read_row,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          plotted,
  output logic [ifs_pkg::PIX_W-1:0]     pixel_col,
  output logic [ifs_pkg::PIX_W-1:0]     pixel_row,
  output logic [ifs_pkg::PIX_W-1:0]     intensity,
  input  logic                          wr_en,
  input  logic [ifs_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [ifs_pkg::DIM_W-1:0]     wr_data
);

  ifs_pkg::ifs_cmd_t    cmd;
  ifs_pkg::ifs_status_t status;

  // sequencer
  ifs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic, framebuffer and output register
  ifs_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .action    (action),
    .choice    (choice),
    .read_col  (read_col),
    .read_row  (read_row),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .plotted   (plotted),
    .pixel_col (pixel_col),
    .pixel_row (pixel_row),
    .intensity (intensity)
  );

endmodule

@@ rtl/ifs_checker.sv @@
`timescale 1ns / 1ps
// ifs_checker: port-level assertions for ifs_fern_point_plotter, plus its bind.
// Depends on ifs_pkg for the pixel width and the intensity step.
module ifs_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      plotted,
  input logic [ifs_pkg::PIX_W-1:0] pixel_col,
  input logic [ifs_pkg::PIX_W-1:0] pixel_row,
  input logic [ifs_pkg::PIX_W-1:0] intensity
);

  // reset empties the output and starts the clearing pass
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!out_valid && in_stall))
    else $error("output valid or input open right after reset");

  // one request at a time: busy right after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block took a request and stayed open");

  // a plotted pixel has gained at least one step
  a_plot_intensity: assert property (@(posedge clk) disable iff (rst)
    (out_valid && plotted) |-> (intensity >= ifs_pkg::PIX_STEP))
    else $error("plotted pixel below one intensity step");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(plotted) && $stable(pixel_col) &&
       $stable(pixel_row) && $stable(intensity)))
    else $error("stalled result changed");

endmodule

bind ifs_fern_point_plotter ifs_checker u_chk (.*);
